// File: rtl/bms_pkg.sv
package bms_pkg;

   // Q30 / Q14 scale points
   localparam logic [31:0] Q30_ONE = 32'h4000_0000;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [45:0] LN2_Q30 = 46'd744261118;
   localparam logic signed [17:0] M0_Q14 = 18'sd16384;
   localparam logic signed [51:0] RND_HALF = 52'sd536870912;

   // decay beyond 30 halvings is flushed to zero
   localparam int EXP_K_MAX = 30;

   // request codes
   localparam logic REQ_RELAX = 1'b0;
   localparam logic REQ_RF    = 1'b1;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      REG_LONG_RELAX  = 2'd0,
      REG_TRANS_RELAX = 2'd1
   } reg_index_type;

   // quadrant of a 16-bit turn angle
   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   // Taylor divisors and floor(2^32 / d)
   localparam int SIN_TERMS = 7;
   localparam int EXP_TERMS = 12;

   localparam logic [7:0] SIN_DIV [SIN_TERMS] =
      '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
   localparam logic [32:0] SIN_RECIP [SIN_TERMS] =
      '{33'd715827882, 33'd214748364, 33'd102261126, 33'd59652323,
        33'd39045157, 33'd27531841, 33'd20452225};

   localparam logic [7:0] COS_DIV [SIN_TERMS] =
      '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};
   localparam logic [32:0] COS_RECIP [SIN_TERMS] =
      '{33'd2147483648, 33'd357913941, 33'd143165576, 33'd76695844,
        33'd47721858, 33'd32537631, 33'd23598721};

   localparam logic [7:0] EXP_DIV [EXP_TERMS] =
      '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12};
   localparam logic [32:0] EXP_RECIP [EXP_TERMS] =
      '{33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
        33'd858993459, 33'd715827882, 33'd613566756, 33'd536870912,
        33'd477218588, 33'd429496729, 33'd390451572, 33'd357913941};

   // k * ln2 in Q30
   function automatic logic [45:0] ln2_times(input logic [4:0] k);
      return 46'(k) * LN2_Q30;
   endfunction

   // Q30 product back to Q14, nearest, ties up
   function automatic logic signed [17:0] rnd30(input logic signed [51:0] v);
      logic signed [51:0] t;
      t = v + RND_HALF;
      return t[47:30];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/bloch_magnetization_step_core.sv
// Channel  Dir  Handshake             Beat contents
// req      in   req_valid/req_stall   type, magnetisation x/y/z, step time,
//                                     off-resonance rate, flip angle, phase
// rsp      out  rsp_valid/rsp_stall   new magnetisation x/y/z, saturated
// csr      in   csr_valid/csr_ready   register index, 24-bit write data
//
// One beat per cycle while rsp is not stalled; the depth from req acceptance to
// rsp_valid is set by the exponential unit (12 Taylor cells of 3 stages each).
// Sync active-high reset clears the valid chain, rsp_valid and both rates.
// The pipeline only halts when rsp holds a beat under rsp_stall and the last
// stage is occupied; while halted every stage holds, bubbles included.
module bloch_magnetization_step_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic signed [15:0] req_mag_x,
   input  logic signed [15:0] req_mag_y,
   input  logic signed [15:0] req_mag_z,
   input  logic [15:0]        req_step_time,
   input  logic signed [31:0] req_off_res_rate,
   input  logic [15:0]        req_flip_angle,
   input  logic [15:0]        req_rf_phase,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata
);
   import bms_pkg::*;

   // stage map: 0 input products, 1 angles, 2..40 trig/exp units,
   // 41..46 three rotation/scale steps, then the rsp register
   localparam int PIPE_LEN  = 47;
   localparam int ANG_DLY   = 15;
   localparam int PAY_DLY   = 39;

   typedef struct packed {
      logic               rtype;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } pay_type;

   typedef struct packed {
      logic [15:0] a0;
      logic [15:0] a1;
      logic [15:0] a2;
   } ang3_type;

   // ---------------- config
   logic [23:0] lrr_ff, trr_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lrr_ff <= '0;
         trr_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_LONG_RELAX:  lrr_ff <= csr_wdata;
            REG_TRANS_RELAX: trr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- flow control
   logic [PIPE_LEN-1:0] vld_ff;
   logic                rsp_valid_ff;
   logic                en, accept;

   assign en        = !vld_ff[PIPE_LEN-1] || !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign accept    = req_valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LEN-2:0], accept};
      end
   end

   // ---------------- stage 0: precession angle and decay exponents
   logic [47:0] ang48;
   logic [31:0] s0_ang32_ff;
   logic [39:0] s0_u1_ff, s0_u2_ff;
   pay_type     s0_pay_ff;
   logic [15:0] s0_flip_ff, s0_phase_ff;

   assign ang48 = 48'(unsigned'(req_off_res_rate)) * 48'(req_step_time);

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ang32_ff <= ang48[31:0];
         s0_u1_ff    <= 40'(req_step_time) * 40'(lrr_ff);
         s0_u2_ff    <= 40'(req_step_time) * 40'(trr_ff);
         s0_pay_ff   <= '{rtype: req_type, x: req_mag_x, y: req_mag_y, z: req_mag_z};
         s0_flip_ff  <= req_flip_angle;
         s0_phase_ff <= req_rf_phase;
      end
   end

   // ---------------- stage 1: turn angles, 16-bit
   logic [31:0] ang_rnd;
   ang3_type    ang_in;
   ang3_type    s1_ang_ff;
   logic [39:0] s1_u1_ff, s1_u2_ff;
   pay_type     s1_pay_ff;

   always_comb begin
      ang_rnd   = s0_ang32_ff + 32'h0000_8000;
      ang_in.a0 = (s0_pay_ff.rtype == REQ_RF) ? 16'd0 - s0_phase_ff : ang_rnd[31:16];
      ang_in.a1 = s0_flip_ff;
      ang_in.a2 = s0_phase_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ang_ff <= ang_in;
         s1_u1_ff  <= s0_u1_ff;
         s1_u2_ff  <= s0_u2_ff;
         s1_pay_ff <= s0_pay_ff;
      end
   end

   // ---------------- alignment lines
   // trig units are 24 deep, exp units 39: angles pass through the ang_dly_ff line
   ang3_type ang_dly_ff [ANG_DLY];
   pay_type  pay_dly_ff [PAY_DLY];

   always_ff @(posedge clock) begin
      if (en) begin
         ang_dly_ff[0] <= s1_ang_ff;
         for (int i = 1; i < ANG_DLY; i++) begin
            ang_dly_ff[i] <= ang_dly_ff[i-1];
         end
         pay_dly_ff[0] <= s1_pay_ff;
         for (int i = 1; i < PAY_DLY; i++) begin
            pay_dly_ff[i] <= pay_dly_ff[i-1];
         end
      end
   end

   // ---------------- units
   logic signed [31:0] s0, c0, s1, c1, s2, c2;
   logic [30:0]        e1, e2;

   bms_sincos u_sc0 (.clock(clock), .en(en), .angle(ang_dly_ff[ANG_DLY-1].a0),
                     .sin_val(s0), .cos_val(c0));
   bms_sincos u_sc1 (.clock(clock), .en(en), .angle(ang_dly_ff[ANG_DLY-1].a1),
                     .sin_val(s1), .cos_val(c1));
   bms_sincos u_sc2 (.clock(clock), .en(en), .angle(ang_dly_ff[ANG_DLY-1].a2),
                     .sin_val(s2), .cos_val(c2));
   bms_exp    u_e1  (.clock(clock), .en(en), .arg(s1_u1_ff), .value(e1));
   bms_exp    u_e2  (.clock(clock), .en(en), .arg(s1_u2_ff), .value(e2));

   // ---------------- stage 41: first z rotation products
   pay_type            p40;
   logic signed [47:0] r1_xc_ff, r1_ys_ff, r1_yc_ff, r1_xs_ff;
   logic signed [15:0] r1_z_ff;
   logic               r1_rf_ff;
   logic [30:0]        r1_e1_ff, r1_e2_ff;
   logic signed [31:0] r1_s1_ff, r1_c1_ff, r1_s2_ff, r1_c2_ff;

   assign p40 = pay_dly_ff[PAY_DLY-1];

   always_ff @(posedge clock) begin
      if (en) begin
         r1_xc_ff <= 48'(p40.x) * 48'(c0);
         r1_ys_ff <= 48'(p40.y) * 48'(s0);
         r1_yc_ff <= 48'(p40.y) * 48'(c0);
         r1_xs_ff <= 48'(p40.x) * 48'(s0);
         r1_z_ff  <= p40.z;
         r1_rf_ff <= (p40.rtype == REQ_RF);
         r1_e1_ff <= e1;
         r1_e2_ff <= e2;
         r1_s1_ff <= s1;
         r1_c1_ff <= c1;
         r1_s2_ff <= s2;
         r1_c2_ff <= c2;
      end
   end

   // ---------------- stage 42: round first rotation
   logic signed [17:0] r2_x_ff, r2_y_ff, r2_z_ff;
   logic               r2_rf_ff;
   logic [30:0]        r2_e1_ff, r2_e2_ff;
   logic signed [31:0] r2_s1_ff, r2_c1_ff, r2_s2_ff, r2_c2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         r2_x_ff  <= rnd30(52'(r1_xc_ff) + 52'(r1_ys_ff));
         r2_y_ff  <= rnd30(52'(r1_yc_ff) - 52'(r1_xs_ff));
         r2_z_ff  <= 18'(r1_z_ff);
         r2_rf_ff <= r1_rf_ff;
         r2_e1_ff <= r1_e1_ff;
         r2_e2_ff <= r1_e2_ff;
         r2_s1_ff <= r1_s1_ff;
         r2_c1_ff <= r1_c1_ff;
         r2_s2_ff <= r1_s2_ff;
         r2_c2_ff <= r1_c2_ff;
      end
   end

   // ---------------- stage 43: x rotation (RF) or relaxation products
   // RF:    q0 = y*c1, q1 = z*s1, q2 = z*c1, q3 = y*s1
   // relax: q0 = x*E2, q1 = y*E2, q2 = (m0 - z)*(1 - E1)
   logic signed [31:0] e2_s, ome1;
   logic signed [17:0] dz;
   logic signed [17:0] a0_op, a1_op, a2_op;
   logic signed [31:0] b0_op, b1_op, b2_op;
   logic signed [49:0] r3_q0_ff, r3_q1_ff, r3_q2_ff, r3_q3_ff;
   logic signed [17:0] r3_x_ff, r3_z_ff;
   logic               r3_rf_ff;
   logic signed [31:0] r3_s2_ff, r3_c2_ff;

   always_comb begin
      e2_s  = signed'(32'(r2_e2_ff));
      ome1  = signed'(Q30_ONE - 32'(r2_e1_ff));
      dz    = M0_Q14 - r2_z_ff;
      a0_op = r2_rf_ff ? r2_y_ff  : r2_x_ff;
      b0_op = r2_rf_ff ? r2_c1_ff : e2_s;
      a1_op = r2_rf_ff ? r2_z_ff  : r2_y_ff;
      b1_op = r2_rf_ff ? r2_s1_ff : e2_s;
      a2_op = r2_rf_ff ? r2_z_ff  : dz;
      b2_op = r2_rf_ff ? r2_c1_ff : ome1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r3_q0_ff <= 50'(a0_op) * 50'(b0_op);
         r3_q1_ff <= 50'(a1_op) * 50'(b1_op);
         r3_q2_ff <= 50'(a2_op) * 50'(b2_op);
         r3_q3_ff <= 50'(r2_y_ff) * 50'(r2_s1_ff);
         r3_x_ff  <= r2_x_ff;
         r3_z_ff  <= r2_z_ff;
         r3_rf_ff <= r2_rf_ff;
         r3_s2_ff <= r2_s2_ff;
         r3_c2_ff <= r2_c2_ff;
      end
   end

   // ---------------- stage 44: round second step
   logic signed [17:0] r4_x_ff, r4_y_ff, r4_z_ff;
   logic               r4_rf_ff;
   logic signed [31:0] r4_s2_ff, r4_c2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (r3_rf_ff) begin
            r4_x_ff <= r3_x_ff;
            r4_y_ff <= rnd30(52'(r3_q0_ff) + 52'(r3_q1_ff));
            r4_z_ff <= rnd30(52'(r3_q2_ff) - 52'(r3_q3_ff));
         end else begin
            r4_x_ff <= rnd30(52'(r3_q0_ff));
            r4_y_ff <= rnd30(52'(r3_q1_ff));
            r4_z_ff <= r3_z_ff + rnd30(52'(r3_q2_ff));
         end
         r4_rf_ff <= r3_rf_ff;
         r4_s2_ff <= r3_s2_ff;
         r4_c2_ff <= r3_c2_ff;
      end
   end

   // ---------------- stage 45: closing z rotation products (RF only)
   logic signed [49:0] r5_xc_ff, r5_ys_ff, r5_yc_ff, r5_xs_ff;
   logic signed [17:0] r5_x_ff, r5_y_ff, r5_z_ff;
   logic               r5_rf_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         r5_xc_ff <= 50'(r4_x_ff) * 50'(r4_c2_ff);
         r5_ys_ff <= 50'(r4_y_ff) * 50'(r4_s2_ff);
         r5_yc_ff <= 50'(r4_y_ff) * 50'(r4_c2_ff);
         r5_xs_ff <= 50'(r4_x_ff) * 50'(r4_s2_ff);
         r5_x_ff  <= r4_x_ff;
         r5_y_ff  <= r4_y_ff;
         r5_z_ff  <= r4_z_ff;
         r5_rf_ff <= r4_rf_ff;
      end
   end

   // ---------------- stage 46: round closing rotation
   logic signed [17:0] r6_x_ff, r6_y_ff, r6_z_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         r6_x_ff <= r5_rf_ff ? rnd30(52'(r5_xc_ff) + 52'(r5_ys_ff)) : r5_x_ff;
         r6_y_ff <= r5_rf_ff ? rnd30(52'(r5_yc_ff) - 52'(r5_xs_ff)) : r5_y_ff;
         r6_z_ff <= r5_z_ff;
      end
   end

   // ---------------- output register, saturate
   logic signed [15:0] out_x_ff, out_y_ff, out_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= vld_ff[PIPE_LEN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         out_x_ff <= sat16(r6_x_ff);
         out_y_ff <= sat16(r6_y_ff);
         out_z_ff <= sat16(r6_z_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;
   assign rsp_out_z = out_z_ff;

endmodule

// File: rtl/bms_term_cell.sv
// One Taylor term: dst_term = ((src_term * src_mul) >> 30) / divisor,
// running sum updated by +/- the new term. Three stages.
module bms_term_cell (
   input  logic               clock,
   input  logic               en,
   input  logic [7:0]         divisor,
   input  logic [32:0]        recip,
   input  logic               subtract,
   input  logic [31:0]        src_term,
   input  logic [31:0]        src_mul,
   input  logic signed [33:0] src_sum,
   output logic [31:0]        dst_term,
   output logic [31:0]        dst_mul,
   output logic signed [33:0] dst_sum
);
   import bms_pkg::*;

   logic [63:0]        prod_ff;
   logic [31:0]        a_ff, est_ff, term_ff;
   logic [31:0]        mul_a_ff, mul_b_ff, mul_c_ff;
   logic signed [33:0] sum_a_ff, sum_b_ff, sum_c_ff;

   logic [64:0]        rp;
   logic [31:0]        est_in;
   logic [39:0]        back;
   logic [31:0]        rem;
   logic [31:0]        term_in;
   logic signed [33:0] sum_in;

   // reciprocal estimate is exact or one low
   always_comb begin
      rp      = 65'(prod_ff[61:30]) * 65'(recip);
      est_in  = rp[63:32];
      back    = 40'(est_ff) * 40'(divisor);
      rem     = a_ff - back[31:0];
      term_in = (rem >= 32'(divisor)) ? est_ff + 32'd1 : est_ff;
      sum_in  = subtract ? sum_b_ff - signed'({2'b00, term_in})
                         : sum_b_ff + signed'({2'b00, term_in});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= 64'(src_term) * 64'(src_mul);
         mul_a_ff <= src_mul;
         sum_a_ff <= src_sum;
         a_ff     <= prod_ff[61:30];
         est_ff   <= est_in;
         mul_b_ff <= mul_a_ff;
         sum_b_ff <= sum_a_ff;
         term_ff  <= term_in;
         mul_c_ff <= mul_b_ff;
         sum_c_ff <= sum_in;
      end
   end

   assign dst_term = term_ff;
   assign dst_mul  = mul_c_ff;
   assign dst_sum  = sum_c_ff;

endmodule

// File: rtl/bms_sincos.sv
// Sine and cosine of a 16-bit turn angle, Q2.30.
module bms_sincos (
   input  logic               clock,
   input  logic               en,
   input  logic [15:0]        angle,
   output logic signed [31:0] sin_val,
   output logic signed [31:0] cos_val
);
   import bms_pkg::*;

   localparam int QD_DEPTH = 3 * SIN_TERMS + 2;

   logic [31:0]  x_ff, xs_ff, x2_ff;
   logic [44:0]  xp;
   logic [63:0]  xx;
   quad_type     qd_ff [QD_DEPTH];
   logic signed [31:0] sin_ff, cos_ff;

   logic [31:0]        sterm [SIN_TERMS+1];
   logic [31:0]        smul  [SIN_TERMS+1];
   logic signed [33:0] ssum  [SIN_TERMS+1];
   logic [31:0]        cterm [SIN_TERMS+1];
   logic [31:0]        cmul  [SIN_TERMS+1];
   logic signed [33:0] csum  [SIN_TERMS+1];

   assign xp = 45'(angle[13:0]) * 45'(HALF_PI_Q30);
   assign xx = 64'(x_ff) * 64'(x_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff     <= 32'(xp[44:14]);
         xs_ff    <= x_ff;
         x2_ff    <= xx[61:30];
         qd_ff[0] <= quad_type'(angle[15:14]);
         for (int i = 1; i < QD_DEPTH; i++) begin
            qd_ff[i] <= qd_ff[i-1];
         end
      end
   end

   assign sterm[0] = xs_ff;
   assign smul[0]  = x2_ff;
   assign ssum[0]  = signed'(34'(xs_ff));
   assign cterm[0] = Q30_ONE;
   assign cmul[0]  = x2_ff;
   assign csum[0]  = signed'(34'(Q30_ONE));

   for (genvar i = 0; i < SIN_TERMS; i++) begin : g_cell
      bms_term_cell u_sin (
         .clock(clock), .en(en),
         .divisor(SIN_DIV[i]), .recip(SIN_RECIP[i]),
         .subtract(1'((i % 2) == 0)),
         .src_term(sterm[i]), .src_mul(smul[i]), .src_sum(ssum[i]),
         .dst_term(sterm[i+1]), .dst_mul(smul[i+1]), .dst_sum(ssum[i+1])
      );
      bms_term_cell u_cos (
         .clock(clock), .en(en),
         .divisor(COS_DIV[i]), .recip(COS_RECIP[i]),
         .subtract(1'((i % 2) == 0)),
         .src_term(cterm[i]), .src_mul(cmul[i]), .src_sum(csum[i]),
         .dst_term(cterm[i+1]), .dst_mul(cmul[i+1]), .dst_sum(csum[i+1])
      );
   end

   logic signed [31:0] sf, cf;
   assign sf = ssum[SIN_TERMS][31:0];
   assign cf = csum[SIN_TERMS][31:0];

   always_ff @(posedge clock) begin
      if (en) begin
         unique case (qd_ff[QD_DEPTH-1])
            QUAD_0: begin sin_ff <= sf;  cos_ff <= cf;  end
            QUAD_1: begin sin_ff <= cf;  cos_ff <= -sf; end
            QUAD_2: begin sin_ff <= -sf; cos_ff <= -cf; end
            QUAD_3: begin sin_ff <= -cf; cos_ff <= sf;  end
            default: begin sin_ff <= sf; cos_ff <= cf;  end
         endcase
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

// File: rtl/bms_exp.sv
// exp(-u), u in Q24, result Q30.
module bms_exp (
   input  logic        clock,
   input  logic        en,
   input  logic [39:0] arg,
   output logic [30:0] value
);
   import bms_pkg::*;

   localparam int KB_DEPTH = 3 * EXP_TERMS + 2;

   typedef struct packed {
      logic       big;
      logic [4:0] k;
   } kb_type;

   logic [45:0]          u30;
   logic [EXP_K_MAX-1:0] ge;
   kb_type               kb_in;
   kb_type               kb_ff [KB_DEPTH];
   logic [34:0]          u30_ff;
   logic [31:0]          r_ff;
   logic [45:0]          kl;
   logic [34:0]          r_in;
   logic [30:0]          value_ff;
   logic [33:0]          sum_u;

   logic [31:0]        eterm [EXP_TERMS+1];
   logic [31:0]        emul  [EXP_TERMS+1];
   logic signed [33:0] esum  [EXP_TERMS+1];

   // k = floor(u / ln2) by a thermometer of compares
   always_comb begin
      u30 = {arg, 6'b0};
      for (int j = 0; j < EXP_K_MAX; j++) begin
         ge[j] = (u30 >= ln2_times(5'(j + 1)));
      end
      kb_in.big = (u30 >= ln2_times(5'(EXP_K_MAX + 1)));
      kb_in.k   = 5'($countones(ge));
      kl        = ln2_times(kb_ff[0].k);
      r_in      = u30_ff - kl[34:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kb_ff[0] <= kb_in;
         for (int i = 1; i < KB_DEPTH; i++) begin
            kb_ff[i] <= kb_ff[i-1];
         end
         u30_ff <= u30[34:0];
         r_ff   <= 32'(r_in[29:0]);
      end
   end

   assign eterm[0] = Q30_ONE;
   assign emul[0]  = r_ff;
   assign esum[0]  = signed'(34'(Q30_ONE));

   for (genvar i = 0; i < EXP_TERMS; i++) begin : g_cell
      bms_term_cell u_term (
         .clock(clock), .en(en),
         .divisor(EXP_DIV[i]), .recip(EXP_RECIP[i]),
         .subtract(1'((i % 2) == 0)),
         .src_term(eterm[i]), .src_mul(emul[i]), .src_sum(esum[i]),
         .dst_term(eterm[i+1]), .dst_mul(emul[i+1]), .dst_sum(esum[i+1])
      );
   end

   assign sum_u = unsigned'(esum[EXP_TERMS]) >> kb_ff[KB_DEPTH-1].k;

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= kb_ff[KB_DEPTH-1].big ? '0 : sum_u[30:0];
      end
   end

   assign value = value_ff;

endmodule

// File: rtl/bms_checker.sv
module bms_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_type,
   input logic signed [15:0] req_mag_x,
   input logic signed [15:0] req_mag_y,
   input logic signed [15:0] req_mag_z,
   input logic [15:0]        req_step_time,
   input logic signed [31:0] req_off_res_rate,
   input logic [15:0]        req_flip_angle,
   input logic [15:0]        req_rf_phase,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_out_x,
   input logic signed [15:0] rsp_out_y,
   input logic signed [15:0] rsp_out_z,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [1:0]         csr_index,
   input logic [23:0]        csr_wdata
);

   // a held beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_z))
      else $error("rsp beat changed under stall");

   // back-pressure only ever comes from a blocked rsp beat
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a blocked rsp beat");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipe not empty after reset");

endmodule

bind bloch_magnetization_step_core bms_checker u_bms_checker (.*);
